>>> rtl/ssdr_pkg.sv
// shared types and constants for the dense rank block
`default_nettype none
package ssdr_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int VALUE_W   = 32;
    localparam int RANK_W    = 9;
    localparam int STATUS_W  = 2;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_SRCH,
        S_APPLY
    } state_t;

    typedef struct packed {
        logic sample;
        logic insert;
    } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sorted_set_dense_rank.sv
// top level: row of score cells with the request sequencer
// sequence: a request is accepted in idle, then the cells compare, the boundary search runs, and the result is applied
// a new request is taken only when busy is low, once the last one is through; the boundary search
//   over the cells' compare flags finds one count bit per cycle
// the result is shown for one cycle on done; the receiver cannot stall it
// reset empties the set; stored scores are not cleared
`default_nettype none
module sorted_set_dense_rank
    import ssdr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          action,
    input  wire logic [VALUE_W-1:0]  value,
    output logic                     done,
    output logic      [RANK_W-1:0]   rank,
    output logic      [STATUS_W-1:0] status
);

    localparam int CW = $clog2(DEPTH + 1);

    cell_ctl_t          cell_ctl;
    logic [VALUE_W-1:0] cell_value;
    logic [CW-1:0]      cell_count;
    logic [CW-1:0]      cell_pos;
    logic [DEPTH-1:0]   gt_vec;
    logic [DEPTH-1:0]   eq_vec;
    logic [VALUE_W-1:0] scores [DEPTH];

    ssdr_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .action     (action),
        .value      (value),
        .gt_vec     (gt_vec),
        .eq_vec     (eq_vec),
        .busy       (busy),
        .done       (done),
        .rank       (rank),
        .status     (status),
        .cell_ctl   (cell_ctl),
        .cell_value (cell_value),
        .cell_count (cell_count),
        .cell_pos   (cell_pos)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] prev_score;

        if (i == 0)
        begin : g_head
            assign prev_score = '0;
        end
        else
        begin : g_link
            assign prev_score = scores[i-1];
        end

        ssdr_cell #(
            .CW    (CW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .value      (cell_value),
            .count      (cell_count),
            .pos        (cell_pos),
            .prev_score (prev_score),
            .score      (scores[i]),
            .gt         (gt_vec[i]),
            .eq         (eq_vec[i])
        );
    end

endmodule
`default_nettype wire

>>> rtl/ssdr_cell.sv
// one cell of the sorted score row: holds a score, compares it, shifts on insert
`default_nettype none
module ssdr_cell
    import ssdr_pkg::*;
#(
    parameter int CW    = 9,
    parameter int INDEX = 0
) (
    input  wire logic               clk,
    input  wire cell_ctl_t          ctl,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic [CW-1:0]      count,
    input  wire logic [CW-1:0]      pos,
    input  wire logic [VALUE_W-1:0] prev_score,
    output logic      [VALUE_W-1:0] score,
    output logic                    gt,
    output logic                    eq
);

    localparam logic [CW:0] IDX = (CW+1)'(INDEX);

    logic [VALUE_W-1:0] score_reg;
    logic               gt_reg;
    logic               eq_reg;
    logic               valid;
    logic               at_pos;
    logic               shift_in;

    assign valid    = IDX < {1'b0, count};
    assign at_pos   = IDX == {1'b0, pos};
    // cells from the insert point up to the old end move one place down
    assign shift_in = (IDX > {1'b0, pos}) && (IDX <= {1'b0, count});

    always_ff @(posedge clk)
    begin
        if (ctl.sample)
        begin
            gt_reg <= valid && (score_reg > value);
            eq_reg <= valid && (score_reg == value);
        end
        if (ctl.insert)
        begin
            if (at_pos)
            begin
                score_reg <= value;
            end
            else if (shift_in)
            begin
                score_reg <= prev_score;
            end
        end
    end

    assign score = score_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;

endmodule
`default_nettype wire

>>> rtl/ssdr_ctrl.sv
// request sequencer: count register, boundary search over the cell flags, result
`default_nettype none
module ssdr_ctrl
    import ssdr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          action,
    input  wire logic [VALUE_W-1:0]  value,
    input  wire logic [DEPTH-1:0]    gt_vec,
    input  wire logic [DEPTH-1:0]    eq_vec,
    output logic                     busy,
    output logic                     done,
    output logic      [RANK_W-1:0]   rank,
    output logic      [STATUS_W-1:0] status,
    output cell_ctl_t                cell_ctl,
    output logic      [VALUE_W-1:0]  cell_value,
    output logic      [CW-1:0]       cell_count,
    output logic      [CW-1:0]       cell_pos
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW = (CW > 1) ? $clog2(CW) : 1;

    state_t             state_reg, state_next;
    action_t            action_reg, action_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [BW-1:0]      bit_reg, bit_next;
    logic               done_reg, done_next;
    logic [RANK_W-1:0]  rank_reg, rank_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [CW:0]        step;
    logic [CW:0]        probe;
    logic [CW:0]        probe_m1;
    logic [CW:0]        pos_inc;
    logic [CW:0]        count_inc;
    logic               dup;

    assign step      = (CW+1)'(1) << bit_reg;
    assign probe     = {1'b0, pos_reg} + step;
    assign probe_m1  = probe - (CW+1)'(1);
    assign pos_inc   = {1'b0, pos_reg} + (CW+1)'(1);
    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign dup       = (pos_reg < count_reg) && eq_vec[pos_reg[IW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        value_reg  <= value_next;
        pos_reg    <= pos_next;
        bit_reg    <= bit_next;
        rank_reg   <= rank_next;
        status_reg <= status_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (bit_reg == '0)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        action_next     = action_reg;
        value_next      = value_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        bit_next        = bit_reg;
        done_next       = 1'b0;
        rank_next       = rank_reg;
        status_next     = status_reg;
        cell_ctl.sample = 1'b0;
        cell_ctl.insert = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action_t'(action);
                    value_next  = value;
                    pos_next    = '0;
                    bit_next    = BW'(CW - 1);
                end
            end
            S_CMP:
            begin
                cell_ctl.sample = 1'b1;
            end
            S_SRCH:
            begin
                // greater flags form a prefix, so find its length one bit at a time
                if ((probe <= (CW+1)'(DEPTH)) && gt_vec[probe_m1[IW-1:0]])
                begin
                    pos_next = probe[CW-1:0];
                end
                bit_next = bit_reg - BW'(1);
            end
            S_APPLY:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                case (action_reg)
                    ACT_CLEAR:
                    begin
                        count_next = '0;
                        rank_next  = '0;
                    end
                    ACT_INSERT:
                    begin
                        if (dup)
                        begin
                            status_next = ST_DUP;
                            rank_next   = RANK_W'(count_reg);
                        end
                        else if (count_reg >= CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            rank_next   = RANK_W'(count_reg);
                        end
                        else
                        begin
                            cell_ctl.insert = 1'b1;
                            count_next      = count_inc[CW-1:0];
                            rank_next       = RANK_W'(count_inc);
                        end
                    end
                    ACT_QUERY:
                    begin
                        rank_next = RANK_W'(pos_inc);
                    end
                    default:
                    begin
                        rank_next = RANK_W'(count_reg);
                    end
                endcase
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign rank       = rank_reg;
    assign status     = status_reg;
    assign cell_value = value_reg;
    assign cell_count = count_reg;
    assign cell_pos   = pos_reg;

endmodule
`default_nettype wire
